@@ src/tccomp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt-compensated compass package
// Sequencer states, register indexes, fixed-point constants and the CORDIC
// arctangent table shared by the compass heading block and its checker.
// ----------------------------------------------------------------------------
package tccomp_pkg;

  // Sequencer phases of the compass datapath.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_ROT_INIT,
    ST_ROT,
    ST_ROT_END,
    ST_PROJ,
    ST_VEC_INIT,
    ST_VEC,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SCALE_X,
    CFG_SCALE_Y,
    CFG_SCALE_Z,
    CFG_BIAS_FWD,
    CFG_BIAS_LEFT,
    CFG_BIAS_UP,
    CFG_INVERT
  } cfg_index_t;

  localparam logic signed [12:0] OVF_MARK      = -13'sd4096;
  localparam logic signed [47:0] CORDIC_K      = 48'sd652032875;
  localparam logic signed [34:0] HALF_PI_Q30   = 35'sd1686629713;
  localparam logic signed [34:0] PI_Q30        = 35'sd3373259426;
  localparam logic signed [15:0] HEADING_LIMIT = 16'sd25736;
  localparam logic signed [15:0] UNIT_MAX      = 16'sd16384;
  localparam logic [14:0]        QUOT_MAX      = 15'd16384;

  // Last step indexes of the multi-cycle phases.
  localparam logic [4:0] SCALE_LAST = 5'd7;
  localparam logic [4:0] SQRT_LAST  = 5'd30;
  localparam logic [4:0] DIV_LAST   = 5'd14;
  localparam logic [4:0] PROJ_LAST  = 5'd6;

  // Arctangent of 2^-i, scaled by 2^30.
  function automatic logic signed [34:0] atan_entry(input logic [4:0] idx);
    logic signed [34:0] val;
    case (idx)
      5'd0:  val = 35'sd843314857;
      5'd1:  val = 35'sd497837830;
      5'd2:  val = 35'sd263043837;
      5'd3:  val = 35'sd133525159;
      5'd4:  val = 35'sd67021687;
      5'd5:  val = 35'sd33543515;
      5'd6:  val = 35'sd16775851;
      5'd7:  val = 35'sd8388438;
      5'd8:  val = 35'sd4194283;
      5'd9:  val = 35'sd2097149;
      5'd10: val = 35'sd1048576;
      5'd11: val = 35'sd524288;
      5'd12: val = 35'sd262144;
      5'd13: val = 35'sd131072;
      5'd14: val = 35'sd65536;
      5'd15: val = 35'sd32768;
      5'd16: val = 35'sd16384;
      5'd17: val = 35'sd8192;
      5'd18: val = 35'sd4096;
      5'd19: val = 35'sd2048;
      5'd20: val = 35'sd1024;
      5'd21: val = 35'sd512;
      5'd22: val = 35'sd256;
      5'd23: val = 35'sd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ src/tilt_compensated_compass_heading.sv @@
`timescale 1ns / 1ps
// Each accepted reading runs from acceptance to a loaded result before the
// block takes a new reading; a reading flagged as overflow goes straight to
// the output state. The datapath is built from one shared 32x20 multiplier,
// a one-bit-per-cycle square root, a one-bit-per-cycle divider run three
// times and one CORDIC stage run for sine/cosine of roll, of pitch and for
// the final arctangent. A finished result sits in an output register, so the
// next reading is accepted while the previous result waits to be taken.
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// Scales, remaps, debiases and normalizes a magnetometer reading, then rotates
// it by roll and pitch and computes the heading as -atan2 of the horizontal
// field components.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading
  import tccomp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [12:0] raw_x,
  input  logic signed [12:0] raw_y,
  input  logic signed [12:0] raw_z,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               valid_res,
  output logic signed [15:0] unit_fwd,
  output logic signed [15:0] unit_left,
  output logic signed [15:0] unit_up,
  output logic signed [15:0] heading,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] comp;
  logic       pass;

  // Configuration registers.
  logic [15:0]        scale_x, scale_y, scale_z;
  logic signed [16:0] bias_fwd, bias_left, bias_up;
  logic               invert_axes;

  // Captured reading.
  logic signed [12:0] rx, ry, rz;
  logic signed [15:0] roll, pitch;
  logic               item_ok;

  // Shared multiplier.
  logic signed [31:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [51:0] prod;
  logic signed [47:0] acc;

  // Scaled and debiased axes.
  logic signed [18:0] sx, sy, sc_val;
  logic signed [18:0] fv, lv, uv;
  logic signed [18:0] f_new, l_new, u_new;

  // Square root.
  logic [61:0] sq_v, sq_r, sq_b, sq_t;
  logic        sq_ge;
  logic [30:0] norm;

  // Divider.
  logic [46:0]        dv_rem, dv_sh;
  logic [14:0]        dv_q, dv_qn, q_cl;
  logic               dv_neg, dv_ge;
  logic signed [18:0] c_sel;
  logic [18:0]        c_abs;
  logic signed [15:0] unit_new;

  // CORDIC stage.
  logic signed [47:0] cx, cy, cx_n, cy_n, x_sh, y_sh, xf, yf;
  logic signed [34:0] cz, cz_n, at, z0;
  logic signed [16:0] ang17;
  logic               cdir, rot_neg, hzero;
  logic signed [16:0] sin_r, cos_r, sin_p, cos_p, cos_new, sin_new;

  // Projection and heading.
  logic signed [31:0] t_val;
  logic signed [47:0] xh, yh;
  logic signed [35:0] hneg, hrnd;
  logic signed [15:0] head_new;

  // Held results.
  logic signed [15:0] hold_vec [3];
  logic signed [15:0] hold_head;

  logic ovf_in, out_load;

  assign ovf_in   = (raw_x == OVF_MARK) || (raw_y == OVF_MARK) || (raw_z == OVF_MARK);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      comp  <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_SQRT) begin
        comp <= '0;
      end else if (state == ST_DIV && cnt == DIV_LAST) begin
        comp <= comp + 2'd1;
      end
      if (state == ST_DIV_INIT) begin
        pass <= 1'b0;
      end else if (state == ST_ROT_END) begin
        pass <= 1'b1;
      end
    end
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    cnt_next   = cnt + 5'd1;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = ovf_in ? ST_OUT : ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (cnt == SCALE_LAST) begin
          state_next = ST_SQRT;
          cnt_next   = '0;
        end
      end
      ST_SQRT: begin
        if (cnt == SQRT_LAST) begin
          state_next = ST_DIV_INIT;
          cnt_next   = '0;
        end
      end
      ST_DIV_INIT: begin
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = (comp == 2'd2) ? ST_ROT_INIT : ST_DIV_INIT;
          cnt_next   = '0;
        end
      end
      ST_ROT_INIT: begin
        state_next = ST_ROT;
        cnt_next   = '0;
      end
      ST_ROT: begin
        if (cnt == ITER_LAST) begin
          state_next = ST_ROT_END;
          cnt_next   = '0;
        end
      end
      ST_ROT_END: begin
        state_next = pass ? ST_PROJ : ST_ROT_INIT;
        cnt_next   = '0;
      end
      ST_PROJ: begin
        if (cnt == PROJ_LAST) begin
          state_next = ST_VEC_INIT;
          cnt_next   = '0;
        end
      end
      ST_VEC_INIT: begin
        state_next = ((xh == '0) && (yh == '0)) ? ST_FINISH : ST_VEC;
        cnt_next   = '0;
      end
      ST_VEC: begin
        if (cnt == ITER_LAST) begin
          state_next = ST_FINISH;
          cnt_next   = '0;
        end
      end
      ST_FINISH: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x     <= 16'd32768;
      scale_y     <= 16'd32768;
      scale_z     <= 16'd32768;
      bias_fwd    <= '0;
      bias_left   <= '0;
      bias_up     <= '0;
      invert_axes <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_SCALE_X:   scale_x     <= cfg_data[15:0];
        CFG_SCALE_Y:   scale_y     <= cfg_data[15:0];
        CFG_SCALE_Z:   scale_z     <= cfg_data[15:0];
        CFG_BIAS_FWD:  bias_fwd    <= $signed(cfg_data);
        CFG_BIAS_LEFT: bias_left   <= $signed(cfg_data);
        CFG_BIAS_UP:   bias_up     <= $signed(cfg_data);
        CFG_INVERT:    invert_axes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SCALE: begin
        case (cnt)
          5'd0: begin mul_a = 32'(rx); mul_b = $signed({4'b0, scale_x}); end
          5'd1: begin mul_a = 32'(ry); mul_b = $signed({4'b0, scale_y}); end
          5'd2: begin mul_a = 32'(rz); mul_b = $signed({4'b0, scale_z}); end
          5'd4: begin mul_a = 32'(fv); mul_b = 20'(fv); end
          5'd5: begin mul_a = 32'(lv); mul_b = 20'(lv); end
          5'd6: begin mul_a = 32'(uv); mul_b = 20'(uv); end
          default: ;
        endcase
      end
      ST_PROJ: begin
        case (cnt)
          5'd0: begin mul_a = 32'(hold_vec[2]); mul_b = 20'(cos_r); end
          5'd1: begin mul_a = 32'(hold_vec[1]); mul_b = 20'(sin_r); end
          5'd2: begin mul_a = 32'(hold_vec[0]); mul_b = 20'(cos_p); end
          5'd3: begin mul_a = t_val;            mul_b = 20'(sin_p); end
          5'd4: begin mul_a = 32'(hold_vec[1]); mul_b = 20'(cos_r); end
          5'd5: begin mul_a = 32'(hold_vec[2]); mul_b = 20'(sin_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Axis rounding, remap and bias removal.
  always_comb begin
    sc_val = 19'((prod + 52'sd1024) >>> 11);
    if (invert_axes) begin
      f_new = sx - 19'(bias_fwd);
      l_new = -sy - 19'(bias_left);
      u_new = sc_val - 19'(bias_up);
    end else begin
      f_new = sy - 19'(bias_fwd);
      l_new = sx - 19'(bias_left);
      u_new = -sc_val - 19'(bias_up);
    end
  end

  // Square root step.
  assign sq_t  = sq_r + sq_b;
  assign sq_ge = (sq_v >= sq_t);
  assign norm  = sq_r[30:0];

  // Divider step and unit component.
  always_comb begin
    case (comp)
      2'd0:    c_sel = fv;
      2'd1:    c_sel = lv;
      default: c_sel = uv;
    endcase
    c_abs = c_sel[18] ? 19'(-c_sel) : 19'(c_sel);
    dv_ge = (dv_rem >= dv_sh);
    dv_qn = {dv_q[13:0], dv_ge};
    q_cl  = (dv_qn > QUOT_MAX) ? QUOT_MAX : dv_qn;
    if (norm == '0) begin
      unit_new = '0;
    end else if (dv_neg) begin
      unit_new = -$signed({1'b0, q_cl});
    end else begin
      unit_new = $signed({1'b0, q_cl});
    end
  end

  // CORDIC stage, shared by rotation and vectoring.
  always_comb begin
    x_sh = cx >>> cnt;
    y_sh = cy >>> cnt;
    at   = atan_entry(cnt);
    cdir = (state == ST_ROT) ? !cz[34] : !(cy > 48'sd0);
    if (cdir) begin
      cx_n = cx - y_sh;
      cy_n = cy + x_sh;
      cz_n = cz - at;
    end else begin
      cx_n = cx + y_sh;
      cy_n = cy - x_sh;
      cz_n = cz + at;
    end
    ang17   = pass ? 17'(pitch) : -17'(roll);
    z0      = 35'(ang17) <<< 17;
    xf      = rot_neg ? -cx : cx;
    yf      = rot_neg ? -cy : cy;
    cos_new = 17'((xf + 48'sd32768) >>> 16);
    sin_new = 17'((yf + 48'sd32768) >>> 16);
    hneg    = -36'(cz);
    hrnd    = (hneg + 36'sd65536) >>> 17;
    if (hzero) begin
      head_new = '0;
    end else if (hrnd > 36'(HEADING_LIMIT)) begin
      head_new = HEADING_LIMIT;
    end else if (hrnd < -36'(HEADING_LIMIT)) begin
      head_new = -HEADING_LIMIT;
    end else begin
      head_new = 16'(hrnd);
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        rx      <= raw_x;
        ry      <= raw_y;
        rz      <= raw_z;
        roll    <= roll_angle;
        pitch   <= pitch_angle;
        item_ok <= !ovf_in;
      end
      ST_SCALE: begin
        case (cnt)
          5'd1: sx <= sc_val;
          5'd2: sy <= sc_val;
          5'd3: begin
            fv <= f_new;
            lv <= l_new;
            uv <= u_new;
          end
          5'd5: acc <= 48'(prod);
          5'd6: acc <= acc + 48'(prod);
          5'd7: begin
            sq_v <= {38'(acc + 48'(prod)), 24'b0};
            sq_r <= '0;
            sq_b <= 62'd1 << 60;
          end
          default: ;
        endcase
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      ST_DIV_INIT: begin
        dv_rem <= 47'({c_abs, 27'b0}) + 47'(norm);
        dv_sh  <= 47'({norm, 15'b0});
        dv_q   <= '0;
        dv_neg <= c_sel[18];
      end
      ST_DIV: begin
        if (dv_ge) begin
          dv_rem <= dv_rem - dv_sh;
        end
        dv_sh <= dv_sh >> 1;
        dv_q  <= dv_qn;
      end
      ST_ROT_INIT: begin
        cx <= CORDIC_K;
        cy <= '0;
        if (z0 > HALF_PI_Q30) begin
          cz      <= z0 - PI_Q30;
          rot_neg <= 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
          cz      <= z0 + PI_Q30;
          rot_neg <= 1'b1;
        end else begin
          cz      <= z0;
          rot_neg <= 1'b0;
        end
      end
      ST_ROT, ST_VEC: begin
        cx <= cx_n;
        cy <= cy_n;
        cz <= cz_n;
      end
      ST_ROT_END: begin
        if (pass) begin
          cos_p <= cos_new;
          sin_p <= sin_new;
        end else begin
          cos_r <= cos_new;
          sin_r <= sin_new;
        end
      end
      ST_PROJ: begin
        case (cnt)
          5'd1: acc   <= 48'(prod);
          5'd2: t_val <= 32'(acc - 48'(prod));
          5'd3: acc   <= 48'(prod) <<< 14;
          5'd4: xh    <= acc + 48'(prod);
          5'd5: acc   <= 48'(prod);
          5'd6: yh    <= (acc + 48'(prod)) <<< 14;
          default: ;
        endcase
      end
      ST_VEC_INIT: begin
        hzero <= (xh == '0) && (yh == '0);
        if (xh[47] && !yh[47]) begin
          cx <= yh;
          cy <= -xh;
          cz <= HALF_PI_Q30;
        end else if (xh[47]) begin
          cx <= -yh;
          cy <= xh;
          cz <= -HALF_PI_Q30;
        end else begin
          cx <= xh;
          cy <= yh;
          cz <= '0;
        end
      end
      default: ;
    endcase
  end

  // Held vector, held heading and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vec[0] <= '0;
      hold_vec[1] <= '0;
      hold_vec[2] <= '0;
      hold_head   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_DIV && cnt == DIV_LAST) begin
        hold_vec[comp] <= unit_new;
      end
      if (state == ST_FINISH) begin
        hold_head <= head_new;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      valid_res <= item_ok;
      unit_fwd  <= hold_vec[0];
      unit_left <= hold_vec[1];
      unit_up   <= hold_vec[2];
      heading   <= hold_head;
    end
  end

endmodule

@@ src/tccomp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading port checker
// Watches the ports of the compass heading block for busy behavior, result
// stability and result ranges.
// ----------------------------------------------------------------------------
module tccomp_port_checker
  import tccomp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               valid_res,
  input logic signed [15:0] unit_fwd,
  input logic signed [15:0] unit_left,
  input logic signed [15:0] unit_up,
  input logic signed [15:0] heading
);

  // One transaction at a time: the block is busy right after accepting one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a reading is still in work");

  // A waiting result holds still.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(unit_fwd)
      && $stable(unit_left) && $stable(unit_up) && $stable(valid_res))
    else $error("pending result changed before it was taken");

  // Unit vector components stay within one in Q1.14.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_fwd <= UNIT_MAX && unit_fwd >= -UNIT_MAX
      && unit_left <= UNIT_MAX && unit_left >= -UNIT_MAX
      && unit_up <= UNIT_MAX && unit_up >= -UNIT_MAX)
    else $error("unit vector component out of range");

  // Heading stays within plus or minus pi.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading <= HEADING_LIMIT && heading >= -HEADING_LIMIT)
    else $error("heading out of range");

endmodule

bind tilt_compensated_compass_heading tccomp_port_checker u_tccomp_port_checker (.*);

@@ test/tccomp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading checker
// Watches the reading and result channels and the register port, predicts
// each result with a fixed-point model of the block and compares field by
// field, in order.
// ----------------------------------------------------------------------------
module tccomp_checker
  import tccomp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [12:0] raw_x,
  input  logic signed [12:0] raw_y,
  input  logic signed [12:0] raw_z,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               valid_res,
  input  logic signed [15:0] unit_fwd,
  input  logic signed [15:0] unit_left,
  input  logic signed [15:0] unit_up,
  input  logic signed [15:0] heading,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 fresh_seen
);

  typedef struct packed {
    logic               ok;
    logic signed [15:0] f;
    logic signed [15:0] l;
    logic signed [15:0] u;
    logic signed [15:0] hd;
  } heading_t;

  heading_t    expected_q[$];
  logic [15:0] gain_x, gain_y, gain_z;
  longint      off_f, off_l, off_u;
  logic        swap_axes;
  longint      keep_f, keep_l, keep_u, keep_h;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint normalize(longint c, longint n);
    longint unsigned mag, q;
    if (n == 0) return 0;
    mag = longint'(c < 0 ? -c : c) << 26;
    q = (2 * mag + n) / (2 * longint'(n));
    if (q > 16384) q = 16384;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint arctan_step(int i);
    return (i < 24) ? longint'(atan_entry(5'(i))) : 0;
  endfunction

  // Rotation CORDIC: sine and cosine of a Q3.13 angle, both Q.14.
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, nx;
    bit     flip;
    z = ang * 131072;
    x = 652032875;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z -= arctan_step(i);
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z += arctan_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_shr(x, 16);
    s = round_shr(y, 16);
  endtask

  // Vectoring CORDIC: atan2 scaled by 2^30.
  function automatic longint angle_of(longint y, longint x);
    longint z, t, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = 64'sd1686629713;
      end else begin
        t = -y; y = x; x = t; z = -64'sd1686629713;
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z += arctan_step(i);
      end else begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z -= arctan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  // Predicted result of one reading; updates the held vector and heading.
  task automatic predict_heading(input longint rx, ry, rz, roll, pitch,
                                 output heading_t r);
    longint sx, sy, sz, f, l, u, sr, cr, sp, cp, t, xh, yh, h, n;
    longint unsigned sum;
    r.ok = 0;
    if (rx != -4096 && ry != -4096 && rz != -4096) begin
      r.ok = 1;
      sx = round_shr(rx * longint'(gain_x), 11);
      sy = round_shr(ry * longint'(gain_y), 11);
      sz = round_shr(rz * longint'(gain_z), 11);
      if (swap_axes) begin
        f = sx; l = -sy; u = sz;
      end else begin
        f = sy; l = sx; u = -sz;
      end
      f -= off_f;
      l -= off_l;
      u -= off_u;
      sum = f * f + l * l + u * u;
      n = root64(sum << 24);
      keep_f = normalize(f, n);
      keep_l = normalize(l, n);
      keep_u = normalize(u, n);
      sin_cos(-roll, sr, cr);
      sin_cos(pitch, sp, cp);
      t = keep_u * cr - keep_l * sr;
      xh = keep_f * cp * 16384 + sp * t;
      yh = (keep_l * cr + keep_u * sr) * 16384;
      h = round_shr(-angle_of(yh, xh), 17);
      if (h > 25736) h = 25736;
      if (h < -25736) h = -25736;
      keep_h = h;
    end
    r.f = 16'(keep_f);
    r.l = 16'(keep_l);
    r.u = 16'(keep_u);
    r.hd = 16'(keep_h);
  endtask

  // Register writes, readings in and results out.
  always @(posedge clk) begin
    heading_t e, got;
    if (rst) begin
      gain_x = 32768; gain_y = 32768; gain_z = 32768;
      off_f = 0; off_l = 0; off_u = 0;
      swap_axes = 0;
      keep_f = 0; keep_l = 0; keep_u = 0; keep_h = 0;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      fresh_seen = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_SCALE_X:   gain_x = cfg_data[15:0];
          CFG_SCALE_Y:   gain_y = cfg_data[15:0];
          CFG_SCALE_Z:   gain_z = cfg_data[15:0];
          CFG_BIAS_FWD:  off_f = longint'($signed(cfg_data));
          CFG_BIAS_LEFT: off_l = longint'($signed(cfg_data));
          CFG_BIAS_UP:   off_u = longint'($signed(cfg_data));
          CFG_INVERT:    swap_axes = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_heading(raw_x, raw_y, raw_z, roll_angle, pitch_angle, e);
        expected_q.push_back(e);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{valid_res, unit_fwd, unit_left, unit_up, heading};
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (e.ok) fresh_seen++;
          if (got.ok !== e.ok) begin
            $error("valid_res expected %0d got %0d", e.ok, got.ok);
            fail_count++;
          end
          if (got.f !== e.f) begin
            $error("unit_fwd expected %0d got %0d", e.f, got.f);
            fail_count++;
          end
          if (got.l !== e.l) begin
            $error("unit_left expected %0d got %0d", e.l, got.l);
            fail_count++;
          end
          if (got.u !== e.u) begin
            $error("unit_up expected %0d got %0d", e.u, got.u);
            fail_count++;
          end
          if (got.hd !== e.hd) begin
            $error("heading expected %0d got %0d", e.hd, got.hd);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ test/tb_tilt_compensated_compass_heading.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading testbench
// Drives directed and random magnetometer readings with random stalls on both
// channels across several register settings; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_compass_heading;
  import tccomp_pkg::*;

  localparam int ITERS       = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [12:0] raw_x = 0, raw_y = 0, raw_z = 0;
  logic signed [15:0] roll_angle = 0, pitch_angle = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               valid_res;
  logic signed [15:0] unit_fwd, unit_left, unit_up, heading;
  logic               cfg_wen = 0;
  logic [2:0]         cfg_index = CFG_SCALE_X;
  logic [16:0]        cfg_data = 0;
  int                 fail_count, pending, results_seen, fresh_seen;
  int                 cycle_count = 0;
  bit                 steady = 0;

  always #5 clk = ~clk;

  tilt_compensated_compass_heading #(.CORDIC_ITERATIONS(ITERS)) u_dut (.*);

  tccomp_checker #(.CORDIC_ITERATIONS(ITERS)) u_checker (.*);

  // Result side: random stalls except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tilt_compensated_compass_heading verification failed");
      $finish;
    end
  end

  // One register write, followed by a quiet cycle on the write port.
  task automatic write_reg(input cfg_index_t idx, input logic [16:0] val);
    cfg_wen   <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 0;
    @(posedge clk);
  endtask

  // One reading transaction; valid is held until accepted and drops only
  // when the source idles.
  task automatic send_reading(input logic signed [12:0] x, y, z,
                              input logic signed [15:0] rl, pt);
    if (!steady && $urandom_range(99) < 7) begin
      in_valid <= 0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 7);
    end
    in_valid    <= 1;
    raw_x       <= x;
    raw_y       <= y;
    raw_z       <= z;
    roll_angle  <= rl;
    pitch_angle <= pt;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [12:0] rand_axis();
    case ($urandom_range(9))
      0:       return -13'sd4096;
      1:       return 13'sd2047;
      2:       return -13'sd4095;
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(7))
      0:       return 16'($urandom);
      1:       return 16'sd25736;
      2:       return -16'sd25736;
      default: return 16'($signed($urandom_range(51472)) - 25736);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    repeat (count) begin
      if ($urandom_range(19) == 0)
        send_reading(rand_axis(), rand_axis(), -13'sd4096, rand_angle(), rand_angle());
      else
        send_reading(rand_axis(), rand_axis(), rand_axis(), rand_angle(), rand_angle());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: overflow before any valid reading, extremes, zero vector.
    send_reading(-13'sd4096, '0, '0, '0, '0);
    send_reading('0, '0, '0, '0, '0);
    send_reading(13'sd2047, 13'sd2047, 13'sd2047, 16'sd25736, -16'sd25736);
    send_reading(-13'sd4095, -13'sd4095, -13'sd4095, -16'sd25736, 16'sd25736);
    send_reading('0, -13'sd4096, 13'sd5, '0, '0);
    send_reading(13'sd5, 13'sd7, -13'sd4096, '0, '0);
    send_reading(13'sd100, 13'sd0, 13'sd0, 16'sh7fff, 16'sh8000);
    send_reading(13'sd0, 13'sd0, 13'sd300, '0, '0);
    send_reading(13'sd0, -13'sd500, 13'sd0, 16'sd12868, 16'sd12868);
    send_reading(-13'sd1, 13'sd1, -13'sd1, -16'sd1, 16'sd1);
    send_reading(13'h0aaa, 13'h1555, 13'h0555, 16'h5555, 16'haaaa);
    drain();

    // Extreme gains, inverted axes, bias cancelling two readings.
    write_reg(CFG_SCALE_X, 17'hffff);
    write_reg(CFG_SCALE_Y, 17'd0);
    write_reg(CFG_SCALE_Z, 17'hffff);
    write_reg(CFG_BIAS_FWD, 17'h10000);
    write_reg(CFG_BIAS_LEFT, 17'h0ffff);
    write_reg(CFG_BIAS_UP, 17'd0);
    write_reg(CFG_INVERT, 17'd1);
    send_reading(13'sd2047, 13'sd2047, 13'sd2047, '0, '0);
    send_reading(-13'sd4095, 13'sd0, -13'sd4095, 16'sd100, -16'sd100);
    drain();
    write_reg(CFG_SCALE_X, 17'd32768);
    write_reg(CFG_BIAS_FWD, 17'd1600);
    write_reg(CFG_BIAS_LEFT, 17'd0);
    send_reading(13'sd100, 13'sd0, 13'sd0, '0, '0);
    send_reading(13'sd100, 13'sd3, 13'sd0, '0, '0);
    drain();

    // Random phases over several settings, one without any stalls.
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_SCALE_X, 17'($urandom));
      write_reg(CFG_SCALE_Y, 17'($urandom_range(65535)));
      write_reg(CFG_SCALE_Z, 17'($urandom_range(65535)));
      write_reg(CFG_BIAS_FWD, 17'($urandom));
      write_reg(CFG_BIAS_LEFT, 17'($urandom));
      write_reg(CFG_BIAS_UP, 17'($signed($urandom_range(4000)) - 2000));
      write_reg(CFG_INVERT, 17'(p % 2));
      steady = (p == 2);
      random_phase(165);
      drain();
      steady = 0;
    end

    $display("Covered %0d results (%0d fresh readings) over reset, extreme and random",
             results_seen, fresh_seen);
    $display("register settings with overflow, zero-vector and out-of-range angles.");
    if (fail_count == 0)
      $display("tilt_compensated_compass_heading verification clean");
    else
      $display("tilt_compensated_compass_heading verification failed");
    $finish;
  end

endmodule
